// File: design/bitmap_text_glyph_blitter_unit_assert.svh
// assertion macros for the bitmap text glyph blitter
`ifndef BITMAP_TEXT_GLYPH_BLITTER_UNIT_ASSERT_SVH
`define BITMAP_TEXT_GLYPH_BLITTER_UNIT_ASSERT_SVH
`ifndef SYNTH
// same-cycle implication, checked out of reset
`define BTGB_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
// next-cycle implication, checked out of reset
`define BTGB_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define BTGB_ASSERT_NOW(lbl, ante, cons, msg)
`define BTGB_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

// File: design/btgb_pkg.sv
// shared types, constants and helpers of the bitmap text glyph blitter
`default_nettype none
package btgb_pkg;

	localparam int MAX_GLYPHS       = 128;
	localparam int MAX_GLYPH_HEIGHT = 16;
	localparam int MAX_GLYPH_WIDTH  = 16;

	// font store geometry: sixteen row words per glyph
	localparam int STORE_DEPTH = 2048;
	localparam int ADDR_W      = 11;
	localparam int ROW_W       = 4;
	localparam int ROWS_W      = 16;
	localparam int CUR_W       = 13;
	localparam int IDX_W       = 24;
	localparam int CFG_IDX_W   = 3;
	localparam int CFG_DATA_W  = 32;
	localparam int PITCH_MAX   = 4096;

	// character codes with special handling
	localparam logic [7:0] CODE_NEWLINE = 8'd10;
	localparam logic [7:0] CODE_SPACE   = 8'd32;

	// request types
	localparam logic REQ_LOAD = 1'b0;
	localparam logic REQ_DRAW = 1'b1;

	// result status codes
	localparam logic STATUS_ROW   = 1'b0;
	localparam logic STATUS_RANGE = 1'b1;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_GLYPH_WIDTH   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_GLYPH_HEIGHT  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_FIRST_CODE    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_GLYPH_COUNT   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_X      = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Y      = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_SURFACE_WIDTH = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_DRAW_COLOR    = 3'd7;

	typedef enum logic [0:0] {
		ST_IDLE,
		ST_DRAW
	} state_t;

	// glyph size limited to 1 .. min(16, cap)
	function automatic logic [4:0] clamp_size(input logic [4:0] v, input int cap);
		int lim;
		logic [4:0] r;
		lim = (cap < 16) ? cap : 16;
		if (lim < 1) lim = 1;
		r = v;
		if (r == 5'd0) r = 5'd1;
		if (int'(r) > lim) r = 5'(lim);
		return r;
	endfunction

	// row pitch limited to 1 .. 4096
	function automatic logic [12:0] clamp_pitch(input logic [12:0] v);
		logic [12:0] r;
		r = v;
		if (r == 13'd0) r = 13'd1;
		if (r > 13'(PITCH_MAX)) r = 13'(PITCH_MAX);
		return r;
	endfunction

	// column mask for a glyph width of 1 .. 16
	function automatic logic [ROWS_W-1:0] width_mask(input logic [4:0] w);
		logic [ROWS_W:0] one_hot;
		one_hot = (ROWS_W+1)'(1) << w;
		return (w >= 5'(ROWS_W)) ? {ROWS_W{1'b1}} : ROWS_W'(one_hot - (ROWS_W+1)'(1));
	endfunction

endpackage
`default_nettype wire

// File: design/bitmap_text_glyph_blitter_unit.sv
// bitmap text glyph blitter: font store, cursor and row sequencer
//
// Input channel (in_valid / in_stall): a load transaction (req_type 0) writes
// row_bits into the font store at row_address; a draw transaction (req_type 1)
// handles char_code at the cursor, start_text first returns the cursor to the
// origin. Output channel (out_valid / out_stall) carries one result per glyph
// row, or one range-error result that drops the rest of the text.
// Configuration: cfg_we / cfg_index / cfg_data write one register per cycle;
// the user must write them only while the block is idle, which goes unchecked.
// Load, newline, space and out-of-range codes are taken while idle; a drawn
// glyph holds the input channel while its rows are read, one row per cycle
// unless the output stalls, from the single read port of the font memory.
// The first row of a glyph passes the sequencer state, the read stage and the
// output register; an error result passes the read stage and output register.
// Reset clears the cursor, the abort flag and the pipeline and loads the
// register defaults; the font store holds no reset value.
// When the receiver stalls, one row waits in the output register and one in
// the read stage; the sequencer and the input channel stall behind them. A new
// transaction is taken while the last result waits, once the read stage empties.
`default_nettype none
`include "bitmap_text_glyph_blitter_unit_assert.svh"
module bitmap_text_glyph_blitter_unit (
	input  wire                              clk,
	input  wire                              arst_n,
	// configuration
	input  wire                              cfg_we,
	input  wire [btgb_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  wire [btgb_pkg::CFG_DATA_W-1:0]   cfg_data,
	// input channel
	input  wire                              in_valid,
	output logic                             in_stall,
	input  wire                              req_type,
	input  wire                              start_text,
	input  wire [7:0]                        char_code,
	input  wire [btgb_pkg::ADDR_W-1:0]       row_address,
	input  wire [btgb_pkg::ROWS_W-1:0]       row_bits,
	// output channel
	output logic                             out_valid,
	input  wire                              out_stall,
	output logic                             status,
	output logic [btgb_pkg::IDX_W-1:0]       pixel_index,
	output logic [btgb_pkg::ROWS_W-1:0]      row_mask,
	output logic [31:0]                      pixel_color,
	output logic                             last_row
);
	import btgb_pkg::*;

	// configuration registers
	logic [4:0]  glyph_width_q;
	logic [4:0]  glyph_height_q;
	logic [7:0]  first_code_q;
	logic [7:0]  glyph_count_q;
	logic [11:0] origin_x_q;
	logic [11:0] origin_y_q;
	logic [12:0] surface_width_q;
	logic [31:0] draw_color_q;

	// text state
	logic [CUR_W-1:0] cursor_x_q, cursor_y_q;
	logic             aborted_q;
	state_t           state_q, state_d;

	// glyph sequencer, line kept one bit wider so rows below the cursor do not wrap
	logic [7:0]        glyph_q;
	logic [ROW_W-1:0]  row_q;
	logic [CUR_W:0]    line_q;
	logic [CUR_W-1:0]  base_x_q;

	// font memory
	logic [ROWS_W-1:0] font_mem [STORE_DEPTH];
	logic [ROWS_W-1:0] rd_data_q;

	// read stage and output register
	logic              s1_valid_s1;
	logic              s1_err_s1;
	logic [IDX_W-1:0]  s1_idx_s1;
	logic              s1_last_s1;
	logic              out_valid_q;
	logic              status_q;
	logic [IDX_W-1:0]  pixel_index_q;
	logic [ROWS_W-1:0] row_mask_q;
	logic [31:0]       pixel_color_q;
	logic              last_row_q;

	// derived values
	logic [4:0]        gw, gh;
	logic [12:0]       pitch;
	logic [ROWS_W-1:0] wmask;
	logic [8:0]        count;
	logic [8:0]        code_off;
	logic              acc, load_acc, draw_acc;
	logic              is_nl, is_sp, in_range;
	logic [CUR_W-1:0]  eff_x, eff_y, cur_x_d, cur_y_d;
	logic              eff_abort, abort_d;
	logic              glyph_go, err_go;
	logic              s1_adv, s1_free, issue, row_last;
	logic [ADDR_W-1:0] rd_addr;
	logic [26:0]       line_prod;
	logic [IDX_W-1:0]  row_idx;

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			glyph_width_q   <= 5'd8;
			glyph_height_q  <= 5'd16;
			first_code_q    <= 8'd32;
			glyph_count_q   <= 8'd96;
			origin_x_q      <= 12'd0;
			origin_y_q      <= 12'd0;
			surface_width_q <= 13'd640;
			draw_color_q    <= 32'hFFFF_FFFF;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_GLYPH_WIDTH:   glyph_width_q   <= cfg_data[4:0];
				REG_GLYPH_HEIGHT:  glyph_height_q  <= cfg_data[4:0];
				REG_FIRST_CODE:    first_code_q    <= cfg_data[7:0];
				REG_GLYPH_COUNT:   glyph_count_q   <= cfg_data[7:0];
				REG_ORIGIN_X:      origin_x_q      <= cfg_data[11:0];
				REG_ORIGIN_Y:      origin_y_q      <= cfg_data[11:0];
				REG_SURFACE_WIDTH: surface_width_q <= cfg_data[12:0];
				REG_DRAW_COLOR:    draw_color_q    <= cfg_data;
				default:           ;
			endcase
		end
	end

	// clamped geometry
	always_comb begin
		gw    = clamp_size(glyph_width_q, MAX_GLYPH_WIDTH);
		gh    = clamp_size(glyph_height_q, MAX_GLYPH_HEIGHT);
		pitch = clamp_pitch(surface_width_q);
		wmask = width_mask(gw);
		count = (9'(glyph_count_q) > 9'(MAX_GLYPHS)) ? 9'(MAX_GLYPHS) : 9'(glyph_count_q);
	end

	// pipeline handshake
	assign s1_adv  = !out_valid_q || !out_stall;
	assign s1_free = !s1_valid_s1 || s1_adv;

	// sequencer next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: if (glyph_go) state_d = ST_DRAW;
			ST_DRAW: if (issue && row_last) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	// sequencer outputs
	always_comb begin
		in_stall = 1'b1;
		issue    = 1'b0;
		case (state_q)
			ST_IDLE: in_stall = !s1_free;
			ST_DRAW: issue    = s1_free;
			default: ;
		endcase
	end

	assign acc      = in_valid && !in_stall;
	assign load_acc = acc && (req_type == REQ_LOAD);
	assign draw_acc = acc && (req_type == REQ_DRAW);

	// classify the draw transaction
	always_comb begin
		eff_x     = start_text ? CUR_W'(origin_x_q) : cursor_x_q;
		eff_y     = start_text ? CUR_W'(origin_y_q) : cursor_y_q;
		eff_abort = start_text ? 1'b0 : aborted_q;
		is_nl     = (char_code == CODE_NEWLINE);
		is_sp     = (char_code == CODE_SPACE);
		code_off  = 9'(char_code) - 9'(first_code_q);
		in_range  = (char_code >= first_code_q) && (code_off < count);
		glyph_go  = draw_acc && !eff_abort && !is_nl && !is_sp && in_range;
		err_go    = draw_acc && !eff_abort && !is_nl && !is_sp && !in_range;
	end

	// cursor update
	always_comb begin
		cur_x_d = eff_x;
		cur_y_d = eff_y;
		abort_d = eff_abort;
		if (!eff_abort) begin
			if (is_nl) begin
				cur_x_d = CUR_W'(origin_x_q);
				cur_y_d = CUR_W'(eff_y + CUR_W'(gh));
			end else if (is_sp || in_range) begin
				cur_x_d = CUR_W'(eff_x + CUR_W'(gw));
			end else begin
				abort_d = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			cursor_x_q <= '0;
			cursor_y_q <= '0;
			aborted_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (draw_acc) begin
				cursor_x_q <= cur_x_d;
				cursor_y_q <= cur_y_d;
				aborted_q  <= abort_d;
			end
		end
	end

	// row counter and line position of the glyph being drawn
	assign row_last = (5'(row_q) == gh - 5'd1);

	always_ff @(posedge clk) begin
		if (glyph_go) begin
			glyph_q  <= code_off[7:0];
			row_q    <= '0;
			line_q   <= (CUR_W+1)'(eff_y);
			base_x_q <= eff_x;
		end else if (issue) begin
			row_q  <= ROW_W'(row_q + ROW_W'(1));
			line_q <= (CUR_W+1)'(line_q + (CUR_W+1)'(1));
		end
	end

	// font memory, write on load, read one row per issue
	assign rd_addr = ADDR_W'({glyph_q, 4'b0000} + 12'(row_q));

	always_ff @(posedge clk) begin
		if (load_acc)
			font_mem[row_address] <= row_bits;
		if (issue)
			rd_data_q <= font_mem[rd_addr];
	end

	// pixel index of the row being issued
	assign line_prod = 27'(line_q) * 27'(pitch);
	assign row_idx   = IDX_W'(line_prod + 27'(base_x_q));

	// read stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			s1_valid_s1 <= 1'b0;
		else if (issue || err_go)
			s1_valid_s1 <= 1'b1;
		else if (s1_adv)
			s1_valid_s1 <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (issue) begin
			s1_err_s1  <= 1'b0;
			s1_idx_s1  <= row_idx;
			s1_last_s1 <= row_last;
		end else if (err_go) begin
			s1_err_s1  <= 1'b1;
			s1_idx_s1  <= '0;
			s1_last_s1 <= 1'b1;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (s1_adv)
			out_valid_q <= s1_valid_s1;
	end

	always_ff @(posedge clk) begin
		if (s1_adv && s1_valid_s1) begin
			status_q      <= s1_err_s1 ? STATUS_RANGE : STATUS_ROW;
			pixel_index_q <= s1_idx_s1;
			row_mask_q    <= s1_err_s1 ? '0 : (rd_data_q & wmask);
			pixel_color_q <= s1_err_s1 ? 32'd0 : draw_color_q;
			last_row_q    <= s1_last_s1;
		end
	end

	assign out_valid   = out_valid_q;
	assign status      = status_q;
	assign pixel_index = pixel_index_q;
	assign row_mask    = row_mask_q;
	assign pixel_color = pixel_color_q;
	assign last_row    = last_row_q;

	// checks
	`BTGB_ASSERT_NOW(a_draw_blocks_input, state_q == ST_DRAW, in_stall, "input taken while drawing")
	`BTGB_ASSERT_NOW(a_no_overrun, issue || err_go, !s1_valid_s1 || s1_adv, "read stage overrun")
	`BTGB_ASSERT_NEXT(a_stage_holds, s1_valid_s1 && !s1_adv, s1_valid_s1 && $stable(s1_idx_s1), "read stage lost while stalled")
	`BTGB_ASSERT_NOW(a_error_shape, out_valid_q && status_q == STATUS_RANGE, last_row_q && row_mask_q == '0, "malformed error result")

endmodule
`default_nettype wire
